// File: sv/birc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// birc_pkg
// Shared types and constants of the bi-phase IR remote decoder.
// ----------------------------------------------------------------------------
package birc_pkg;

    localparam int TICKS_PER_PERIOD = 256;
    localparam int PRESCALE_W       = $clog2(TICKS_PER_PERIOD);

    localparam int TICK_W   = 8;
    localparam int PERIOD_W = 4;
    localparam int SHIFT_W  = 7;
    localparam int CMD_W    = 6;
    localparam int KEY_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [TICK_W-1:0]     TICK_MAX   = 8'd255;
    localparam logic [PERIOD_W-1:0]   PERIOD_MAX = 4'd15;
    localparam logic [PRESCALE_W-1:0] PRESCALE_LAST = PRESCALE_W'(TICKS_PER_PERIOD - 1);
    localparam logic [KEY_W-1:0]      NO_KEY     = 7'd64;

    localparam logic [7:0] SILENCE_RESET = 8'd49;
    localparam logic [7:0] SAMPLE_RESET  = 8'd16;
    localparam logic [3:0] RELEASE_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_PERIODS = 2'd2;

    typedef struct packed {
        logic [7:0] silence_ticks;
        logic [7:0] sample_delay;
        logic [3:0] release_periods;
    } birc_cfg_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] code;
    } birc_result_t;

endpackage

// File: sv/birc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// birc_core
// Frame search, bit sampling, command extraction and key release, one tick per item.
// ----------------------------------------------------------------------------
module birc_core
    import birc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic         ir_active,
    input  birc_cfg_t    cfg,
    output birc_result_t result
);

    typedef enum logic [2:0] {
        PH_SEARCH    = 3'd0,
        PH_SILENCE   = 3'd1,
        PH_WAIT_EDGE = 3'd2,
        PH_SAMPLE    = 3'd3,
        PH_EDGE      = 3'd4
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic                  last_level_reg, last_level_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [PRESCALE_W-1:0] prescale_reg, prescale_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [SHIFT_W-1:0]    shift_reg, shift_next;

    logic [TICK_W-1:0]     tick_adv;
    logic [PERIOD_W-1:0]   period_adv;
    logic [PRESCALE_W-1:0] prescale_adv;
    logic                  wrap;

    always_comb
    begin
        tick_adv     = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 1'b1;
        wrap         = (prescale_reg == PRESCALE_LAST);
        prescale_adv = wrap ? '0 : prescale_reg + 1'b1;
        period_adv   = (wrap && period_reg != PERIOD_MAX) ? period_reg + 1'b1 : period_reg;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        last_level_next = last_level_reg;
        tick_next       = tick_reg;
        prescale_next   = prescale_reg;
        period_next     = period_reg;
        shift_next      = shift_reg;
        result          = '0;
        if (step)
        begin
            tick_next     = tick_adv;
            prescale_next = prescale_adv;
            period_next   = period_adv;
            unique case (phase_reg)
                PH_SILENCE:
                begin
                    if (ir_active == last_level_reg)
                    begin
                        if (tick_adv > cfg.silence_ticks)
                        begin
                            phase_next  = PH_WAIT_EDGE;
                            period_next = '0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_SEARCH;
                    end
                end
                PH_WAIT_EDGE:
                begin
                    if (ir_active != last_level_reg)
                    begin
                        phase_next = PH_SAMPLE;
                        tick_next  = '0;
                        shift_next = '0;
                    end
                    else if (period_adv > cfg.release_periods)
                    begin
                        result.valid = 1'b1;
                        result.code  = NO_KEY;
                    end
                end
                PH_SAMPLE:
                begin
                    if (tick_adv > cfg.sample_delay)
                    begin
                        phase_next      = PH_EDGE;
                        last_level_next = ir_active;
                        shift_next      = {shift_reg[SHIFT_W-2:0], ir_active};
                    end
                end
                PH_EDGE:
                begin
                    if (ir_active != last_level_reg)
                    begin
                        last_level_next = ir_active;
                        phase_next      = PH_SAMPLE;
                        tick_next       = '0;
                    end
                    else if (tick_adv > cfg.silence_ticks)
                    begin
                        phase_next   = PH_SEARCH;
                        result.valid = 1'b1;
                        result.code  = {1'b0, ~shift_reg[CMD_W:1]};
                    end
                end
                default:
                begin
                    tick_next       = '0;
                    last_level_next = ir_active;
                    phase_next      = PH_SILENCE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SEARCH;
            last_level_reg <= 1'b0;
            tick_reg       <= '0;
            prescale_reg   <= '0;
            period_reg     <= '0;
            shift_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            last_level_reg <= last_level_next;
            tick_reg       <= tick_next;
            prescale_reg   <= prescale_next;
            period_reg     <= period_next;
            shift_reg      <= shift_next;
        end
    end

endmodule

// File: sv/biphase_ir_remote_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biphase_ir_remote_decoder
// Bi-phase IR remote decoder: one receiver sample per item, key codes out.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry ir_active, one sample tick per
// item. Output channel: out_valid / out_stall carry key_code, 0..63 for a
// decoded command or 64 for no key pressed; a tick yields zero or one item.
// Config channel: cfg_valid / cfg_ready (always ready) write cfg_data to
// register cfg_index: 0 silence_ticks, 1 sample_delay, 2 release_periods;
// index 3 is ignored. Write only while the decoder is idle.
// Output: a result is registered and appears on out_valid in the cycle after its tick is taken.
// Throughput: one tick per cycle while in_stall is low; the decoder state
// updates in a single registered step per tick.
// Reset: registers return to 49 / 16 / 8, decoder restarts its frame search,
// output register empties.
// Stall: while a result waits under out_stall, in_stall is raised; the
// output register is freed and refilled in the same cycle it is taken.
// ----------------------------------------------------------------------------
module biphase_ir_remote_decoder
    import birc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  ir_active,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KEY_W-1:0]      key_code,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    birc_cfg_t        cfg_reg;
    birc_result_t     result;
    logic             step;
    logic             out_valid_reg, out_valid_next;
    logic [KEY_W-1:0] key_code_reg, key_code_next;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign step      = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign key_code  = key_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.silence_ticks   <= SILENCE_RESET;
            cfg_reg.sample_delay    <= SAMPLE_RESET;
            cfg_reg.release_periods <= RELEASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SILENCE_TICKS:   cfg_reg.silence_ticks   <= cfg_data;
                REG_SAMPLE_DELAY:    cfg_reg.sample_delay    <= cfg_data;
                REG_RELEASE_PERIODS: cfg_reg.release_periods <= cfg_data[3:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    birc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .ir_active (ir_active),
        .cfg       (cfg_reg),
        .result    (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        key_code_next  = key_code_reg;
        if (!in_stall)
        begin
            out_valid_next = result.valid;
            key_code_next  = result.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_code_reg <= key_code_next;
    end

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output register");

    a_result_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> step)
        else $error("result produced without an accepted tick");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (key_code <= NO_KEY))
        else $error("key code out of range");

    a_new_result_follows_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.valid) |=> out_valid)
        else $error("result lost in output register");

endmodule

// File: verif/biphase_ir_remote_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biphase_ir_remote_decoder_tb
// Self-checking bench for the bi-phase IR remote decoder. A queue of receiver
// samples, made of well-formed bi-phase frames, broken frames, line noise and
// long steady stretches, feeds a driver with random gaps. A monitor predicts
// every key item from its own decoder model and compares it with the output,
// while the receiver stalls at random and once holds off long enough to back
// the decoder up. Registers are reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module biphase_ir_remote_decoder_tb;
    import birc_pkg::*;

    localparam int                   IDLE_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        ST_SEARCH,
        ST_SILENCE,
        ST_WAIT_EDGE,
        ST_SAMPLE,
        ST_EDGE
    } dec_state_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic                  ir_active = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b1;
    logic [KEY_W-1:0]      key_code;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // decoder model
    birc_cfg_t              rx_cfg;
    dec_state_t             dec_state;
    logic                   held_level;
    logic [TICK_W-1:0]      tick_cnt;
    logic [PRESCALE_W-1:0]  prescale_cnt;
    logic [PERIOD_W-1:0]    period_cnt;
    logic [SHIFT_W-1:0]     shift_reg;

    logic             ir_samples_q[$];
    logic [KEY_W-1:0] key_expect_q[$];
    logic             line_level    = 1'b0;
    int               queued_ticks  = 0;
    logic             tick_taken    = 1'b0;
    bit               calm          = 1'b0;
    bit               pressure_done = 1'b0;
    int               err_count     = 0;
    int               ticks_taken   = 0;
    int               keys_checked  = 0;
    int               nokey_count   = 0;
    int               reg_writes    = 0;
    int               send_gap      = 0;
    int               send_quiet    = 0;
    int               recv_gap      = 0;
    int               recv_quiet    = 0;
    int               hold_left     = 0;
    int               idle_cycles   = 0;

    biphase_ir_remote_decoder i_dut (.*);

    always #5 clk = ~clk;

    function automatic bit decode_tick(input logic level, output logic [KEY_W-1:0] key);
        bit emit;
        emit = 1'b0;
        key  = '0;
        if (tick_cnt != TICK_MAX)
        begin
            tick_cnt++;
        end
        if (prescale_cnt == PRESCALE_LAST)
        begin
            prescale_cnt = '0;
            if (period_cnt != PERIOD_MAX)
            begin
                period_cnt++;
            end
        end
        else
        begin
            prescale_cnt++;
        end
        case (dec_state)
            ST_SILENCE:
            begin
                if (level != held_level)
                begin
                    dec_state = ST_SEARCH;
                end
                else if (tick_cnt > rx_cfg.silence_ticks)
                begin
                    dec_state  = ST_WAIT_EDGE;
                    period_cnt = '0;
                end
            end
            ST_WAIT_EDGE:
            begin
                if (level != held_level)
                begin
                    dec_state = ST_SAMPLE;
                    tick_cnt  = '0;
                    shift_reg = '0;
                end
                else if (period_cnt > rx_cfg.release_periods)
                begin
                    emit = 1'b1;
                    key  = NO_KEY;
                end
            end
            ST_SAMPLE:
            begin
                if (tick_cnt > rx_cfg.sample_delay)
                begin
                    dec_state  = ST_EDGE;
                    held_level = level;
                    shift_reg  = {shift_reg[SHIFT_W-2:0], level};
                end
            end
            ST_EDGE:
            begin
                if (level != held_level)
                begin
                    held_level = level;
                    dec_state  = ST_SAMPLE;
                    tick_cnt   = '0;
                end
                else if (tick_cnt > rx_cfg.silence_ticks)
                begin
                    dec_state = ST_SEARCH;
                    emit      = 1'b1;
                    key       = {1'b0, ~shift_reg[CMD_W:1]};
                end
            end
            default:
            begin
                tick_cnt   = '0;
                held_level = level;
                dec_state  = ST_SILENCE;
            end
        endcase
        return emit;
    endfunction

    task automatic push_level(input logic level, input int count);
        repeat (count)
        begin
            ir_samples_q.push_back(level);
            queued_ticks++;
        end
        line_level = level;
    endtask

    // start bit leaves the idle level at mid-bit, then data bits MSB first
    task automatic push_frame(input int h, input logic [13:0] data, input int nbits);
        logic bit_val;
        bit_val = ~line_level;
        push_level(~bit_val, h);
        push_level(bit_val, h);
        for (int i = nbits - 1; i >= 0; i--)
        begin
            bit_val = data[i];
            push_level(~bit_val, h);
            push_level(bit_val, h);
        end
    endtask

    task automatic fill_phase(input int h, input int sil, input int target, input bit with_frames);
        int first;
        int pick;
        int n;
        first = queued_ticks;
        while (queued_ticks - first < target)
        begin
            pick = $urandom_range(0, 99);
            if (with_frames && pick < 70)
            begin
                push_frame(h, 14'($urandom), $urandom_range(1, 13));
                push_level(line_level, 2 * sil + 4 + $urandom_range(0, 8));
            end
            else if (pick < 80)
            begin
                n = $urandom_range(2, 20);
                repeat (n) push_level(~line_level, $urandom_range(1, 2 * h));
            end
            else if (pick < 92)
            begin
                n = $urandom_range(1, 16);
                repeat (n) push_level(1'($urandom_range(0, 1)), 1);
            end
            else
            begin
                push_level(line_level, $urandom_range(40, 300));
            end
        end
    endtask

    task automatic program_decoder(input logic [7:0] sil, input logic [7:0] smp,
                                   input logic [3:0] rel);
        logic [CFG_IDX_W-1:0] idx[4];
        logic [CFG_DATA_W-1:0] val[4];
        idx = '{REG_SILENCE_TICKS, REG_SAMPLE_DELAY, REG_RELEASE_PERIODS, REG_UNUSED};
        val = '{sil, smp, {4'($urandom), rel}, 8'($urandom)};
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (ir_samples_q.size() != 0 || in_valid || key_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || tick_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (ir_samples_q.size() != 0)
            begin
                in_valid  <= 1'b1;
                ir_active <= ir_samples_q.pop_front();
                if (!calm)
                begin
                    if (send_quiet > 0)
                    begin
                        send_quiet--;
                    end
                    else if ($urandom_range(0, 1) == 1)
                    begin
                        send_gap = $urandom_range(1, 7);
                    end
                    else
                    begin
                        send_quiet = $urandom_range(5, 40);
                    end
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!pressure_done && ticks_taken > 700 && out_valid)
        begin
            pressure_done = 1'b1;
            hold_left     = 59;
            out_stall <= 1'b1;
        end
        else if (calm || !rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_stall <= 1'b1;
        end
        else if (recv_quiet > 0)
        begin
            recv_quiet--;
            out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 1) == 1)
        begin
            recv_gap = $urandom_range(1, 7) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            recv_quiet = $urandom_range(5, 40);
            out_stall <= 1'b0;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        logic [KEY_W-1:0] key_want;
        if (!rst_n)
        begin
            rx_cfg       = '{SILENCE_RESET, SAMPLE_RESET, RELEASE_RESET};
            dec_state    = ST_SEARCH;
            held_level   = 1'b0;
            tick_cnt     = '0;
            prescale_cnt = '0;
            period_cnt   = '0;
            shift_reg    = '0;
            tick_taken <= 1'b0;
        end
        else
        begin
            tick_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (key_expect_q.size() == 0)
                begin
                    $error("key_code: unexpected item, actual %0d", key_code);
                    err_count++;
                end
                else
                begin
                    key_want = key_expect_q.pop_front();
                    keys_checked++;
                    if (key_want == NO_KEY)
                    begin
                        nokey_count++;
                    end
                    if (key_code !== key_want)
                    begin
                        $error("key_code mismatch: expected %0d, actual %0d", key_want, key_code);
                        err_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                case (cfg_index)
                    REG_SILENCE_TICKS:   rx_cfg.silence_ticks   = cfg_data;
                    REG_SAMPLE_DELAY:    rx_cfg.sample_delay    = cfg_data;
                    REG_RELEASE_PERIODS: rx_cfg.release_periods = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                ticks_taken++;
                if (decode_tick(ir_active, key_want))
                begin
                    key_expect_q.push_back(key_want);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: %0d key items still expected", key_expect_q.size());
            $display("biphase_ir_remote_decoder_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int h;
        int sil;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        program_decoder(8'd4, 8'd1, 4'd0);
        push_level(1'b0, 6);
        push_frame(2, 14'b10, 2);
        push_level(line_level, 7);
        settle();

        program_decoder(8'd0, 8'd0, 4'd0);
        fill_phase(2, 0, 100, 1'b0);
        settle();

        repeat (6)
        begin
            h   = $urandom_range(2, 5);
            sil = 2 * h + $urandom_range(0, 6);
            program_decoder(8'(sil), 8'(h - 1 + $urandom_range(0, h - 1)),
                            4'($urandom_range(0, 3)));
            fill_phase(h, sil, 120, 1'b1);
            settle();
        end

        program_decoder(8'd255, 8'd255, 4'd15);
        fill_phase(4, 255, 130, 1'b0);
        settle();

        program_decoder(8'd254, 8'd254, 4'd14);
        fill_phase(4, 254, 100, 1'b0);
        settle();

        calm = 1'b1;
        h    = $urandom_range(2, 4);
        sil  = 2 * h + 2;
        program_decoder(8'(sil), 8'(h), 4'd0);
        fill_phase(h, sil, 120, 1'b1);
        settle();
        repeat (10) @(posedge clk);

        $display("covered %0d ticks and %0d key items (%0d no-key), %0d register writes",
                 ticks_taken, keys_checked, nokey_count, reg_writes);
        $display("long receiver hold-off %s", pressure_done ? "applied" : "not reached");
        if (err_count == 0)
        begin
            $display("biphase_ir_remote_decoder_tb OK");
        end
        else
        begin
            $display("biphase_ir_remote_decoder_tb NOT OK");
        end
        $finish;
    end

endmodule
